>>> rtl/ksc_pkg.sv
// ----------------------------------------------------------------------------
// ksc_pkg
// Widths, codes and shared types of the kinetic scroll controller.
// ----------------------------------------------------------------------------
package ksc_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int COORD_BITS = 16;
    localparam int MARGIN_PX  = 25;

    // Field and state widths.
    localparam int OFF_W  = 26;
    localparam int VEL_W  = COORD_BITS + 1 + FRAC_BITS;
    localparam int ANC_W  = 27;
    localparam int RNG_W  = COORD_BITS + FRAC_BITS;
    localparam int WRK_W  = 30;
    localparam int DT_W   = 16;
    localparam int MODE_W = 2;
    localparam int ACT_W  = 2;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = DT_W + 4;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // 11*dt/2^17 is the glide decay 5.5*dt, 7*dt/2^16 the rebound closing rate.
    localparam int GLIDE_SHIFT = 17;
    localparam int REB_SHIFT   = 16;

    localparam int VEL_MAX  = ((1 << COORD_BITS) - 1) * (1 << FRAC_BITS);
    localparam int MARGIN_Q = MARGIN_PX * (1 << FRAC_BITS);
    // Largest magnitude that still counts as below 0.1 pixel.
    localparam int STOP_MAX = ((1 << FRAC_BITS) - 1) / 10;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CONTENT_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_LEN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USER_EN     = 2'd2;

    localparam logic [ACT_W-1:0] ACT_PRESS   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DRAG    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_TICK    = 2'd3;

    localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DRAG    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GLIDE   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_REBOUND = 2'd3;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              valid;
        logic [PROD_W-1:0] prod;
    } t_mul_rsp;

endpackage

>>> rtl/ksc_mul.sv
// ----------------------------------------------------------------------------
// ksc_mul
// Shared registered multiplier for the glide decay and the rebound step.
// ----------------------------------------------------------------------------
module ksc_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ksc_pkg::t_mul_req i_req,
    output ksc_pkg::t_mul_rsp o_rsp
);
    import ksc_pkg::*;

    logic              r_valid;
    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_req.start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_prod <= PROD_W'(i_req.a) * PROD_W'(i_req.b);
        end
    end

    assign o_rsp.valid = r_valid;
    assign o_rsp.prod  = r_prod;

endmodule

>>> rtl/kinetic_scroll_controller.sv
// ----------------------------------------------------------------------------
// kinetic_scroll_controller
// One-axis kinetic scroller with drag, glide and overscroll rebound.
// ----------------------------------------------------------------------------
// Input words carry an event kind on s_tuser (press, drag, release, tick) and
// the pointer positions and tick duration on s_tdata. Every input word yields
// one output word on m_tdata: the scroll offset, velocity and mode after the
// event. Content and view lengths and the drag enable are written through the
// plain write port; the user must write them only while the block is idle,
// which the block does not enforce. The block takes one word at a time. A
// press, a release, an ignored drag, a tick that changes nothing or a rebound
// snap goes from the prepare step to the done step; a drag passes through the
// offset add and clamp; a glide or rebound step passes through the shared
// multiplier, the apply step and the offset add and clamp. s_tready rises
// together with the output word. If the receiver stalls, the finished result
// of the following word waits inside the block with s_tready low until the
// output register is free.
// Reset clears the offset, velocity, anchor and mode to idle, both lengths to
// zero and sets the drag enable.
// ----------------------------------------------------------------------------
module kinetic_scroll_controller (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ksc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ksc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // pointer_pos[15:0], prev_pointer_pos[31:16], time_step[47:32]
    input  logic [47:0]                    s_tdata,
    // action[1:0]
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // scroll_offset[25:0], scroll_velocity[50:26], scroll_mode[52:51], zero[55:53]
    output logic [55:0]                    m_tdata
);
    import ksc_pkg::*;

    localparam int OUT_W = 56;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PREP  = 6'b000010,
        S_MUL   = 6'b000100,
        S_APPLY = 6'b001000,
        S_PLACE = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    localparam logic signed [WRK_W-1:0] VEL_MAX_W  = WRK_W'(VEL_MAX);
    localparam logic signed [WRK_W-1:0] MARGIN_Q_W = WRK_W'(MARGIN_Q);
    localparam logic signed [WRK_W-1:0] STOP_W     = WRK_W'(STOP_MAX);

    t_state r_state, n_state;

    logic [CFG_DATA_W-1:0] r_content_len;
    logic [CFG_DATA_W-1:0] r_view_len;
    logic                  r_user_en;

    logic [ACT_W-1:0]      r_action;
    logic [COORD_BITS-1:0] r_pos;
    logic [COORD_BITS-1:0] r_prev;
    logic [DT_W-1:0]       r_dt;

    logic signed [OFF_W-1:0] r_offset, n_offset;
    logic signed [VEL_W-1:0] r_vel, n_vel;
    logic signed [ANC_W-1:0] r_anchor, n_anchor;
    logic [MODE_W-1:0]       r_mode, n_mode;

    logic [MUL_A_W-1:0]      r_mul_a, n_mul_a;
    logic [MUL_B_W-1:0]      r_mul_b, n_mul_b;
    logic                    r_neg, n_neg;
    logic signed [WRK_W-1:0] r_arg, n_arg;
    logic                    r_use_sum, n_use_sum;
    logic                    r_halt_en, n_halt_en;

    logic             r_m_valid;
    logic [OUT_W-1:0] r_m_data;
    logic             n_load;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    logic [RNG_W-1:0]        range_q;
    logic [CFG_DATA_W-1:0]   len_diff;
    logic signed [WRK_W-1:0] w_range, w_neg_range, w_lo, w_hi;
    logic signed [WRK_W-1:0] w_off, w_vel, w_anc, w_pos_q;
    logic signed [WRK_W-1:0] w_vel_abs, w_d;
    logic signed [COORD_BITS:0] w_step;
    logic signed [VEL_W-1:0] w_drag_vel;
    logic                    w_below, w_above, w_d_small;
    logic [MUL_B_W-1:0]      w_dt11, w_dt7;
    logic signed [WRK_W-1:0] w_red_g, w_red_r, w_mag, w_diff, w_diff_sat, w_vnew;
    logic signed [WRK_W-1:0] w_x_new, w_arg, w_clamped;
    logic                    w_stop, w_lo_hit, w_hi_hit;

    ksc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    assign mul_req.start = (r_state == S_MUL);
    assign mul_req.a     = r_mul_a;
    assign mul_req.b     = r_mul_b;

    // Scroll range in Q.8 and the clamp window around it.
    assign len_diff    = r_content_len - r_view_len;
    assign range_q     = (r_content_len > r_view_len) ?
                         {len_diff, {FRAC_BITS{1'b0}}} : '0;
    assign w_range     = $signed({{(WRK_W-RNG_W){1'b0}}, range_q});
    assign w_neg_range = -w_range;
    assign w_lo        = -(w_range + MARGIN_Q_W);
    assign w_hi        = MARGIN_Q_W;

    assign w_off   = $signed({{(WRK_W-OFF_W){r_offset[OFF_W-1]}}, r_offset});
    assign w_vel   = $signed({{(WRK_W-VEL_W){r_vel[VEL_W-1]}}, r_vel});
    assign w_anc   = $signed({{(WRK_W-ANC_W){r_anchor[ANC_W-1]}}, r_anchor});
    assign w_pos_q = $signed({{(WRK_W-RNG_W){1'b0}}, r_pos, {FRAC_BITS{1'b0}}});

    assign w_step     = $signed({1'b0, r_pos}) - $signed({1'b0, r_prev});
    assign w_drag_vel = $signed({w_step, {FRAC_BITS{1'b0}}});

    assign w_vel_abs = (w_vel < 0) ? -w_vel : w_vel;

    // Overscroll distance past whichever bound the offset lies beyond.
    assign w_below   = (w_off < w_neg_range);
    assign w_above   = (w_off > 0);
    assign w_d       = w_below ? (w_neg_range - w_off) : w_off;
    assign w_d_small = (w_d <= STOP_W);

    assign w_dt11 = MUL_B_W'({r_dt, 3'b000}) + MUL_B_W'({r_dt, 1'b0}) + MUL_B_W'(r_dt);
    assign w_dt7  = MUL_B_W'({r_dt, 3'b000}) - MUL_B_W'(r_dt);

    // Glide: shrink the magnitude, allowing it to cross zero, then saturate.
    assign w_red_g = $signed({{(WRK_W-(PROD_W-GLIDE_SHIFT)){1'b0}},
                              mul_rsp.prod[PROD_W-1:GLIDE_SHIFT]});
    assign w_red_r = $signed({{(WRK_W-(PROD_W-REB_SHIFT)){1'b0}},
                              mul_rsp.prod[PROD_W-1:REB_SHIFT]});
    assign w_mag      = $signed({{(WRK_W-MUL_A_W){1'b0}}, r_mul_a});
    assign w_diff     = w_mag - w_red_g;
    assign w_diff_sat = (w_diff < -VEL_MAX_W) ? -VEL_MAX_W : w_diff;
    assign w_vnew     = r_neg ? -w_diff_sat : w_diff_sat;
    assign w_stop     = (w_diff_sat <= STOP_W) && (w_diff_sat >= -STOP_W);

    assign w_x_new = r_neg ? (w_off + w_red_r) : (w_off - w_red_r);

    // Offset placement: the offset-plus-velocity add or a prepared target, feeding the window clamp.
    assign w_arg     = r_use_sum ? (w_off + w_vel) : r_arg;
    assign w_lo_hit  = (w_arg < w_lo);
    assign w_hi_hit  = (w_arg > w_hi);
    assign w_clamped = w_lo_hit ? w_lo : (w_hi_hit ? w_hi : w_arg);

    always_comb begin
        n_state   = r_state;
        n_offset  = r_offset;
        n_vel     = r_vel;
        n_anchor  = r_anchor;
        n_mode    = r_mode;
        n_mul_a   = r_mul_a;
        n_mul_b   = r_mul_b;
        n_neg     = r_neg;
        n_arg     = r_arg;
        n_use_sum = r_use_sum;
        n_halt_en = r_halt_en;
        n_load    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = S_DONE;
                unique case (r_action)
                    ACT_PRESS: begin
                        n_anchor = ANC_W'(w_pos_q - w_off);
                    end
                    ACT_DRAG: begin
                        if (r_user_en) begin
                            n_mode    = MODE_DRAG;
                            n_vel     = w_drag_vel;
                            n_arg     = w_pos_q - w_anc;
                            n_use_sum = 1'b0;
                            n_halt_en = 1'b1;
                            n_state   = S_PLACE;
                        end
                    end
                    ACT_RELEASE: begin
                        n_mode = (w_off >= w_neg_range && w_off <= 0) ?
                                 MODE_GLIDE : MODE_REBOUND;
                    end
                    ACT_TICK: begin
                        if (r_mode == MODE_GLIDE) begin
                            n_mul_a = w_vel_abs[MUL_A_W-1:0];
                            n_mul_b = w_dt11;
                            n_neg   = r_vel[VEL_W-1];
                            n_state = S_MUL;
                        end else if (r_mode == MODE_REBOUND && (w_below || w_above)) begin
                            n_neg = w_below;
                            if (w_d_small) begin
                                // Close enough: snap onto the bound and stop.
                                n_offset = w_below ? w_neg_range[OFF_W-1:0] : '0;
                                n_vel    = '0;
                            end else begin
                                n_mul_a = w_d[MUL_A_W-1:0];
                                n_mul_b = w_dt7;
                                n_state = S_MUL;
                            end
                        end
                    end
                endcase
            end
            S_MUL: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                n_state = S_PLACE;
                if (r_mode == MODE_GLIDE) begin
                    if (w_stop) begin
                        n_vel  = '0;
                        n_mode = MODE_REBOUND;
                    end else begin
                        n_vel = w_vnew[VEL_W-1:0];
                    end
                    n_use_sum = 1'b1;
                    n_halt_en = 1'b1;
                end else begin
                    // A rebound step may overshoot; it is clamped but keeps velocity.
                    n_arg     = w_x_new;
                    n_use_sum = 1'b0;
                    n_halt_en = 1'b0;
                end
            end
            S_PLACE: begin
                n_offset = w_clamped[OFF_W-1:0];
                if ((w_lo_hit || w_hi_hit) && r_halt_en) begin
                    n_vel = '0;
                    if (r_mode == MODE_GLIDE) begin
                        n_mode = MODE_REBOUND;
                    end
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_m_valid || m_tready) begin
                    n_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_offset      <= '0;
            r_vel         <= '0;
            r_anchor      <= '0;
            r_mode        <= MODE_IDLE;
            r_m_valid     <= 1'b0;
            r_content_len <= '0;
            r_view_len    <= '0;
            r_user_en     <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_offset <= n_offset;
            r_vel    <= n_vel;
            r_anchor <= n_anchor;
            r_mode   <= n_mode;
            if (r_m_valid && m_tready) begin
                r_m_valid <= 1'b0;
            end
            if (n_load) begin
                r_m_valid <= 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CONTENT_LEN: r_content_len <= i_cfg_data;
                    CFG_VIEW_LEN:    r_view_len    <= i_cfg_data;
                    CFG_USER_EN:     r_user_en     <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_action <= s_tuser;
            r_pos    <= s_tdata[15:0];
            r_prev   <= s_tdata[31:16];
            r_dt     <= s_tdata[47:32];
        end
        r_mul_a   <= n_mul_a;
        r_mul_b   <= n_mul_b;
        r_neg     <= n_neg;
        r_arg     <= n_arg;
        r_use_sum <= n_use_sum;
        r_halt_en <= n_halt_en;
        if (n_load) begin
            r_m_data <= {{(OUT_W-OFF_W-VEL_W-MODE_W){1'b0}}, r_mode, r_vel, r_offset};
        end
    end

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

    // Once the scroller has left idle, no event brings it back.
    a_mode_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_IDLE) |=> (r_mode != MODE_IDLE))
        else $error("scroll mode returned to idle");

    // The product must be ready in the cycle that applies it.
    a_mul_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |-> mul_rsp.valid)
        else $error("multiplier result missing in apply step");

    // Reported velocity never exceeds the saturation bound.
    a_vel_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (w_vel <= VEL_MAX_W && w_vel >= -VEL_MAX_W))
        else $error("velocity beyond saturation bound");

    // A finished result with a free output register is presented next cycle.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!m_tvalid || m_tready)) |=>
        (m_tvalid && r_state == S_IDLE))
        else $error("finished result not delivered to output register");

endmodule
